/* rtl/core/m3i_pkg.sv */
// Shared widths, lane count and register map of the 3x3 matrix inverse.
// Used by m3i_div and matrix3_inverse_top; depends on nothing else.
package m3i_pkg;

  localparam int ELEM_W    = 32;  // Q16.16 element
  localparam int PROD_W    = 64;  // element product
  localparam int COF_W     = 65;  // signed cross-product term
  localparam int COFM_W    = 64;  // cross-product magnitude
  localparam int DET_W     = 97;  // signed determinant
  localparam int DETM_W    = 96;  // determinant magnitude
  localparam int NUM_W     = 98;  // dividend 2*|cof|*2^32 + |det|
  localparam int QUO_W     = 32;  // quotient bits kept
  localparam int LANES     = 9;
  localparam int DIV_STEPS = 32;
  localparam int FE_STG    = 7;   // front-end register stages

  localparam int TOL_W     = 31;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

  // register index, taken from paddr[2]
  localparam logic REG_DET_TOL = 1'b0;

  typedef struct packed {
    logic vld;
    logic sing;
  } m3i_ctl_t;

endpackage

/* rtl/core/m3i_div.sv */
// Pipelined restoring divider array for nine lanes, one quotient bit per stage,
// followed by rounding-free saturation, sign and singular masking. Uses m3i_pkg.
module m3i_div import m3i_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  m3i_ctl_t          ctl_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [LANES-1:0]  neg_i,
  input  logic [DET_W-1:0]  den_i,
  output logic              out_valid_o,
  output logic              out_sing_o,
  output logic [QUO_W-1:0]  quo_o [LANES]
);

  logic [DIV_STEPS:0]   vld_r;
  logic [DIV_STEPS:0]   sing_r;
  logic [LANES-1:0]     neg_r  [0:DIV_STEPS];
  logic [LANES-1:0]     ovf_r  [0:DIV_STEPS];
  logic [DET_W-1:0]     den_r  [0:DIV_STEPS];
  logic [DET_W-1:0]     rem_r  [0:DIV_STEPS][LANES];
  logic [QUO_W-1:0]     nlo_r  [0:DIV_STEPS][LANES];
  logic [QUO_W-1:0]     quo_r  [0:DIV_STEPS][LANES];

  logic                 out_valid_r;
  logic                 out_sing_r;
  logic [QUO_W-1:0]     out_q_r [LANES];
  logic [QUO_W-1:0]     out_q_nxt [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV_STEPS-1:0], ctl_i.vld};
      out_valid_r <= vld_r[DIV_STEPS];
    end
  end

  // entry stage: overflow check on the high dividend bits, seed remainder
  logic [LANES-1:0] ovf0_nxt;
  for (genvar gl = 0; gl < LANES; gl++) begin : g_entry
    logic [NUM_W-QUO_W-1:0] hi;
    assign hi = num_i[gl][NUM_W-1:QUO_W];
    assign ovf0_nxt[gl] = {{(DET_W-NUM_W+QUO_W){1'b0}}, hi} >= den_i;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][gl] <= {{(DET_W-NUM_W+QUO_W){1'b0}}, hi};
        nlo_r[0][gl] <= num_i[gl][QUO_W-1:0];
        quo_r[0][gl] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= ctl_i.sing;
      neg_r[0]  <= neg_i;
      ovf_r[0]  <= ovf0_nxt;
      den_r[0]  <= den_i;
    end
  end

  for (genvar gs = 1; gs <= DIV_STEPS; gs++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        sing_r[gs] <= sing_r[gs-1];
        neg_r[gs]  <= neg_r[gs-1];
        ovf_r[gs]  <= ovf_r[gs-1];
        den_r[gs]  <= den_r[gs-1];
      end
    end
    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
      logic [DET_W:0]   trial;
      logic [DET_W+1:0] diff;
      logic             ge;
      logic [DET_W-1:0] rem_nxt;
      assign trial   = {rem_r[gs-1][gl], nlo_r[gs-1][gl][QUO_W-1]};
      assign diff    = {1'b0, trial} - {2'b00, den_r[gs-1]};
      assign ge      = !diff[DET_W+1];
      assign rem_nxt = ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[gs][gl] <= rem_nxt;
          nlo_r[gs][gl] <= {nlo_r[gs-1][gl][QUO_W-2:0], 1'b0};
          quo_r[gs][gl] <= {quo_r[gs-1][gl][QUO_W-2:0], ge};
        end
      end
    end
  end

  // saturate to the Q16.16 limit of the result sign, zero when singular
  for (genvar gl = 0; gl < LANES; gl++) begin : g_out
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    logic [QUO_W-1:0] q;
    assign q   = quo_r[DIV_STEPS][gl];
    assign lim = neg_r[DIV_STEPS][gl] ? {1'b1, {(QUO_W-1){1'b0}}}
                                      : {1'b0, {(QUO_W-1){1'b1}}};
    assign mag = (ovf_r[DIV_STEPS][gl] || q > lim) ? lim : q;
    assign out_q_nxt[gl] = sing_r[DIV_STEPS] ? '0 :
                           (neg_r[DIV_STEPS][gl] ? (~mag + 1'b1) : mag);
    always_ff @(posedge clk) begin
      if (en) begin
        out_q_r[gl] <= out_q_nxt[gl];
      end
    end
    assign quo_o[gl] = out_q_r[gl];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sing_r <= sing_r[DIV_STEPS];
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_sing_o  = out_sing_r;

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sing_r |-> out_q_r[0] == '0 && out_q_r[1] == '0 &&
      out_q_r[2] == '0 && out_q_r[3] == '0 && out_q_r[4] == '0 &&
      out_q_r[5] == '0 && out_q_r[6] == '0 && out_q_r[7] == '0 && out_q_r[8] == '0)
    else $error("singular result carries nonzero elements");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline valid bits moved while held");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

/* rtl/core/matrix3_inverse_top.sv */
// Top level of the 3x3 Q16.16 matrix inverse: front-end products, cofactors,
// determinant and dividend set-up; division in m3i_div. Uses m3i_pkg.
//
// Takes one matrix per clock unless held and returns its inverse through seven
// front-end stages (products, cross terms, split 64x32 determinant products,
// sum, magnitudes, dividend set-up), a 33-stage restoring divider array (an
// entry stage, then one quotient bit per stage) in each of nine lanes, and the
// output register. The whole pipeline advances together; it holds only while a
// result waits at the output under stall. det_tolerance is read at the
// magnitude compare stage, so write it only with the pipeline empty.
module matrix3_inverse_top import m3i_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [ELEM_W-1:0] in_r0_c0,
  input  logic signed [ELEM_W-1:0] in_r0_c1,
  input  logic signed [ELEM_W-1:0] in_r0_c2,
  input  logic signed [ELEM_W-1:0] in_r1_c0,
  input  logic signed [ELEM_W-1:0] in_r1_c1,
  input  logic signed [ELEM_W-1:0] in_r1_c2,
  input  logic signed [ELEM_W-1:0] in_r2_c0,
  input  logic signed [ELEM_W-1:0] in_r2_c1,
  input  logic signed [ELEM_W-1:0] in_r2_c2,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [ELEM_W-1:0] out_r0_c0,
  output logic signed [ELEM_W-1:0] out_r0_c1,
  output logic signed [ELEM_W-1:0] out_r0_c2,
  output logic signed [ELEM_W-1:0] out_r1_c0,
  output logic signed [ELEM_W-1:0] out_r1_c1,
  output logic signed [ELEM_W-1:0] out_r1_c2,
  output logic signed [ELEM_W-1:0] out_r2_c0,
  output logic signed [ELEM_W-1:0] out_r2_c1,
  output logic signed [ELEM_W-1:0] out_r2_c2,
  output logic              out_singular
);

  logic en;
  logic [TOL_W-1:0] tol_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_DET_TOL) begin
      tol_r <= cfg_pwdata[TOL_W-1:0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_DET_TOL) ? {1'b0, tol_r} : '0;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [ELEM_W-1:0] m [3][3];
  assign m[0][0] = in_r0_c0;  assign m[0][1] = in_r0_c1;  assign m[0][2] = in_r0_c2;
  assign m[1][0] = in_r1_c0;  assign m[1][1] = in_r1_c1;  assign m[1][2] = in_r1_c2;
  assign m[2][0] = in_r2_c0;  assign m[2][1] = in_r2_c1;  assign m[2][2] = in_r2_c2;

  logic [FE_STG-1:0] fe_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_vld_r <= '0;
    end else if (en) begin
      fe_vld_r <= {fe_vld_r[FE_STG-2:0], in_valid};
    end
  end

  logic signed [PROD_W-1:0] p1_r  [LANES];
  logic signed [PROD_W-1:0] p2_r  [LANES];
  logic signed [COF_W-1:0]  cr_r  [LANES];
  logic signed [COF_W-1:0]  cr3_r [LANES];
  logic signed [COF_W-1:0]  cr4_r [LANES];
  logic signed [COF_W-1:0]  cr5_r [LANES];
  logic [COFM_W-1:0]        cofabs_r [LANES];
  logic [LANES-1:0]         cneg_r;
  logic signed [ELEM_W-1:0] x1_r [3];
  logic signed [ELEM_W-1:0] x2_r [3];
  logic [PROD_W-1:0]        pl_r [3];
  logic [PROD_W-1:0]        ph_r [3];
  logic [2:0]               tneg_r;
  logic signed [DET_W-1:0]  term_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic [DETM_W-1:0]        dabs_r;
  logic                     dneg_r;
  logic                     sing_r;
  logic [NUM_W-1:0]         num_r [LANES];
  logic [LANES-1:0]         neg_r;
  logic [DET_W-1:0]         den_r;

  // inverse row r, element e: (column r+1 x column r+2) component e
  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    localparam int R = gl / 3;
    localparam int E = gl % 3;
    localparam int J = (R + 1) % 3;
    localparam int K = (R + 2) % 3;
    localparam int A = (E + 1) % 3;
    localparam int B = (E + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[gl]     <= m[A][J] * m[B][K];
        p2_r[gl]     <= m[B][J] * m[A][K];
        cr_r[gl]     <= COF_W'(p1_r[gl]) - COF_W'(p2_r[gl]);
        cr3_r[gl]    <= cr_r[gl];
        cr4_r[gl]    <= cr3_r[gl];
        cr5_r[gl]    <= cr4_r[gl];
        cofabs_r[gl] <= cr5_r[gl][COF_W-1] ? COFM_W'(-cr5_r[gl]) : cr5_r[gl][COFM_W-1:0];
        cneg_r[gl]   <= cr5_r[gl][COF_W-1];
        num_r[gl]    <= {cofabs_r[gl], 33'd0} + {2'b00, dabs_r};
        neg_r[gl]    <= cneg_r[gl] ^ dneg_r;
      end
    end
  end

  // determinant along column 0; 64x32 products split into two 32x32 halves
  for (genvar ge = 0; ge < 3; ge++) begin : g_det
    logic [COF_W-1:0]   crabs;
    logic [ELEM_W:0]    xabs;
    logic [DETM_W-1:0]  tsum;
    assign crabs = cr_r[ge][COF_W-1] ? (~$unsigned(cr_r[ge]) + 1'b1) : $unsigned(cr_r[ge]);
    assign xabs  = x2_r[ge][ELEM_W-1] ? (~{1'b1, $unsigned(x2_r[ge])} + 1'b1)
                                       : {1'b0, $unsigned(x2_r[ge])};
    assign tsum  = {ph_r[ge], 32'd0} + {32'd0, pl_r[ge]};
    always_ff @(posedge clk) begin
      if (en) begin
        x1_r[ge]   <= m[ge][0];
        x2_r[ge]   <= x1_r[ge];
        pl_r[ge]   <= crabs[31:0] * xabs[ELEM_W-1:0];
        ph_r[ge]   <= crabs[COFM_W-1:32] * xabs[ELEM_W-1:0];
        tneg_r[ge] <= x2_r[ge][ELEM_W-1] ^ cr_r[ge][COF_W-1];
        term_r[ge] <= tneg_r[ge] ? -$signed({1'b0, tsum}) : $signed({1'b0, tsum});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= term_r[0] + term_r[1] + term_r[2];
      dabs_r <= det_r[DET_W-1] ? DETM_W'(-det_r) : det_r[DETM_W-1:0];
      dneg_r <= det_r[DET_W-1];
      sing_r <= dabs_r <= {33'd0, tol_r, 32'd0};
      den_r  <= {dabs_r, 1'b0};
    end
  end

  m3i_ctl_t div_ctl;
  assign div_ctl.vld  = fe_vld_r[FE_STG-1];
  assign div_ctl.sing = sing_r;

  logic [QUO_W-1:0] quo [LANES];

  m3i_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (div_ctl),
    .num_i       (num_r),
    .neg_i       (neg_r),
    .den_i       (den_r),
    .out_valid_o (out_valid),
    .out_sing_o  (out_singular),
    .quo_o       (quo)
  );

  assign out_r0_c0 = $signed(quo[0]);
  assign out_r0_c1 = $signed(quo[1]);
  assign out_r0_c2 = $signed(quo[2]);
  assign out_r1_c0 = $signed(quo[3]);
  assign out_r1_c1 = $signed(quo[4]);
  assign out_r1_c2 = $signed(quo[5]);
  assign out_r2_c0 = $signed(quo[6]);
  assign out_r2_c1 = $signed(quo[7]);
  assign out_r2_c2 = $signed(quo[8]);

endmodule
